// File: hdl/cdad_pkg.sv
package cdad_pkg;

  localparam int REM_W = 17;

  localparam logic [13:0] YEAR_MIN = 14'd1;
  localparam logic [13:0] YEAR_MAX = 14'd9999;
  localparam logic [8:0]  CYCLE_YEARS = 9'd400;
  localparam logic [8:0]  CYCLE_LAST = 9'd399;
  localparam logic [3:0]  MONTH_FIRST = 4'd1;
  localparam logic [3:0]  MONTH_LAST = 4'd12;
  localparam logic [4:0]  DAY_LAST_DEC = 5'd31;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_PREP,
    ST_YEAR,
    ST_MONTH,
    ST_DONE
  } state_t;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  typedef struct packed {
    alu_op_t    op;
    logic [8:0] operand;
  } alu_req_t;

  typedef struct packed {
    logic signed [REM_W-1:0] sum;
    logic                    neg;
  } alu_rsp_t;

  // leap test on the year taken modulo 400
  function automatic logic leap_of(input logic [8:0] r);
    return (r[1:0] == 2'b00) && (r != 9'd100) && (r != 9'd200) && (r != 9'd300);
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    unique case (m)
      4'd2:                      len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

  // days in the months before month m of a common year
  function automatic logic [8:0] days_before(input logic [3:0] m);
    logic [8:0] n;
    unique case (m)
      4'd2:    n = 9'd31;
      4'd3:    n = 9'd59;
      4'd4:    n = 9'd90;
      4'd5:    n = 9'd120;
      4'd6:    n = 9'd151;
      4'd7:    n = 9'd181;
      4'd8:    n = 9'd212;
      4'd9:    n = 9'd243;
      4'd10:   n = 9'd273;
      4'd11:   n = 9'd304;
      4'd12:   n = 9'd334;
      default: n = 9'd0;
    endcase
    return n;
  endfunction

  function automatic logic [8:0] year_len(input logic leap);
    return leap ? 9'd366 : 9'd365;
  endfunction

endpackage

// File: hdl/cdad_alu.sv
module cdad_alu import cdad_pkg::*; (
  input  logic signed [REM_W-1:0] rem,
  input  alu_req_t                req,
  output alu_rsp_t                rsp
);

  logic signed [REM_W-1:0] opnd;

  assign opnd = $signed({{(REM_W-9){1'b0}}, req.operand});

  always_comb begin
    unique case (req.op)
      ALU_ADD: rsp.sum = rem + opnd;
      ALU_SUB: rsp.sum = rem - opnd;
      default: rsp.sum = rem;
    endcase
    rsp.neg = rsp.sum[REM_W-1];
  end

endmodule

// File: hdl/calendar_date_add_days_core.sv
// the shared adder first reduces the year modulo 400, then adds the day of year of the start
// date to the offset, then crosses one year per cycle (forward or back) and finally one
// month per cycle
// throughput: one item at a time; in_ready is high only while the sequencer is idle,
// a finished result waits in the output register without blocking the next transfer
// reset: synchronous rst clears the sequencer and the output valid flag
module calendar_date_add_days_core import cdad_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [4:0]         day_in,
  input  logic [3:0]         month_in,
  input  logic [13:0]        year_in,
  input  logic signed [15:0] day_offset,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [4:0]         day_out,
  output logic [3:0]         month_out,
  output logic [13:0]        year_out,
  output logic               input_valid,
  output logic               range_overflow
);

  state_t st, st_next;

  logic signed [15:0]      off;
  logic [4:0]              d_raw;
  logic [4:0]              d_res, d_res_next;
  logic [3:0]              mon, mon_next;
  logic [13:0]             yr, yr_next;
  logic [8:0]              r400, r400_next;
  logic signed [REM_W-1:0] rem, rem_next;
  logic                    vld, vld_next;
  logic                    ovf, ovf_next;

  alu_req_t alu_req;
  alu_rsp_t alu_rsp;

  logic       in_xfer;
  logic       out_load;
  logic [3:0] mon_clamp;
  logic [13:0] yr_clamp;
  logic       leap_cur, leap_prev;
  logic [8:0] r_prev, r_succ;
  logic [4:0] len_cur, d_clamp;
  logic [8:0] doy;

  cdad_alu u_alu (
    .rem (rem),
    .req (alu_req),
    .rsp (alu_rsp)
  );

  assign in_ready = (st == ST_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign out_load = (st == ST_DONE) && (!out_valid || out_ready);

  always_comb begin
    mon_clamp = month_in;
    if (month_in < MONTH_FIRST) mon_clamp = MONTH_FIRST;
    if (month_in > MONTH_LAST)  mon_clamp = MONTH_LAST;
    yr_clamp = year_in;
    if (year_in < YEAR_MIN) yr_clamp = YEAR_MIN;
    if (year_in > YEAR_MAX) yr_clamp = YEAR_MAX;
  end

  assign leap_cur  = leap_of(r400);
  assign r_prev    = (r400 == 9'd0) ? CYCLE_LAST : r400 - 9'd1;
  assign r_succ    = (r400 == CYCLE_LAST) ? 9'd0 : r400 + 9'd1;
  assign leap_prev = leap_of(r_prev);
  assign len_cur   = month_len(mon, leap_cur);

  always_comb begin
    d_clamp = d_raw;
    if (d_raw == 5'd0)   d_clamp = 5'd1;
    if (d_raw > len_cur) d_clamp = len_cur;
  end

  // zero-based day of year of the clamped start date
  assign doy = days_before(mon) + {8'd0, leap_cur && (mon > 4'd2)} + {4'd0, d_clamp} - 9'd1;

  // next state
  always_comb begin
    st_next = st;
    unique case (st)
      ST_IDLE:  if (in_xfer) st_next = ST_MOD;
      ST_MOD:   if (alu_rsp.neg) st_next = ST_PREP;
      ST_PREP:  st_next = ST_YEAR;
      ST_YEAR: begin
        if (rem[REM_W-1]) begin
          if (yr == YEAR_MIN) st_next = ST_DONE;
        end else if (alu_rsp.neg) begin
          st_next = ST_MONTH;
        end else if (yr == YEAR_MAX) begin
          st_next = ST_DONE;
        end
      end
      ST_MONTH: if (mon == MONTH_LAST || alu_rsp.neg) st_next = ST_DONE;
      ST_DONE:  if (out_load) st_next = ST_IDLE;
      default:  st_next = ST_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    alu_req    = '{op: ALU_SUB, operand: CYCLE_YEARS};
    rem_next   = rem;
    r400_next  = r400;
    yr_next    = yr;
    mon_next   = mon;
    d_res_next = d_res;
    vld_next   = vld;
    ovf_next   = ovf;
    unique case (st)
      ST_IDLE: begin
        if (in_xfer) begin
          mon_next = mon_clamp;
          yr_next  = yr_clamp;
          vld_next = (month_in >= MONTH_FIRST) && (month_in <= MONTH_LAST) &&
                     (year_in >= YEAR_MIN) && (year_in <= YEAR_MAX);
          ovf_next = 1'b0;
          rem_next = $signed({{(REM_W-14){1'b0}}, yr_clamp});
        end
      end
      ST_MOD: begin
        if (alu_rsp.neg) begin
          r400_next = rem[8:0];
          rem_next  = $signed({{(REM_W-16){off[15]}}, off});
        end else begin
          rem_next = alu_rsp.sum;
        end
      end
      ST_PREP: begin
        alu_req  = '{op: ALU_ADD, operand: doy};
        rem_next = alu_rsp.sum;
        mon_next = MONTH_FIRST;
        vld_next = vld && (d_raw != 5'd0) && (d_raw <= len_cur);
      end
      ST_YEAR: begin
        if (rem[REM_W-1]) begin
          alu_req = '{op: ALU_ADD, operand: year_len(leap_prev)};
          if (yr == YEAR_MIN) begin
            ovf_next   = 1'b1;
            d_res_next = 5'd1;
            mon_next   = MONTH_FIRST;
          end else begin
            yr_next   = yr - 14'd1;
            r400_next = r_prev;
            rem_next  = alu_rsp.sum;
          end
        end else begin
          alu_req = '{op: ALU_SUB, operand: year_len(leap_cur)};
          if (!alu_rsp.neg) begin
            if (yr == YEAR_MAX) begin
              ovf_next   = 1'b1;
              d_res_next = DAY_LAST_DEC;
              mon_next   = MONTH_LAST;
            end else begin
              yr_next   = yr + 14'd1;
              r400_next = r_succ;
              rem_next  = alu_rsp.sum;
            end
          end
        end
      end
      ST_MONTH: begin
        alu_req = '{op: ALU_SUB, operand: {4'd0, len_cur}};
        if (mon == MONTH_LAST || alu_rsp.neg) begin
          d_res_next = rem[4:0] + 5'd1;
        end else begin
          rem_next = alu_rsp.sum;
          mon_next = mon + 4'd1;
        end
      end
      ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_IDLE;
    end else begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    rem   <= rem_next;
    r400  <= r400_next;
    yr    <= yr_next;
    mon   <= mon_next;
    d_res <= d_res_next;
    vld   <= vld_next;
    ovf   <= ovf_next;
    if (in_xfer) begin
      off   <= day_offset;
      d_raw <= day_in;
    end
  end

  // output register, loaded once the previous result has been transferred
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      day_out        <= d_res;
      month_out      <= mon;
      year_out       <= yr;
      input_valid    <= vld;
      range_overflow <= ovf;
    end
  end

  a_r400_bound: assert property (@(posedge clk) disable iff (rst)
    (st == ST_YEAR || st == ST_MONTH) |-> (r400 < CYCLE_YEARS))
    else $error("year residue out of range");

  a_month_walk_range: assert property (@(posedge clk) disable iff (rst)
    (st == ST_MONTH) |-> (!rem[REM_W-1] && (rem < 17'sd366)))
    else $error("day of year out of range during month walk");

  a_result_date: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (day_out >= 5'd1) && (month_out >= MONTH_FIRST) &&
                  (month_out <= MONTH_LAST) && (year_out >= YEAR_MIN) &&
                  (year_out <= YEAR_MAX))
    else $error("result date out of range");

  a_overflow_limit: assert property (@(posedge clk) disable iff (rst)
    (out_valid && range_overflow) |->
      ((year_out == YEAR_MIN && month_out == MONTH_FIRST && day_out == 5'd1) ||
       (year_out == YEAR_MAX && month_out == MONTH_LAST && day_out == DAY_LAST_DEC)))
    else $error("saturated result is not a range limit");

endmodule
